FILE: hdl/scfp_pkg.sv
// Shared types and constants of the serial command frame parser.
package scfp_pkg;

    localparam logic [7:0] SYNC_0      = 8'hAA;
    localparam logic [7:0] SYNC_1      = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
    localparam logic [7:0] MAX_LEN     = 8'd49;
    localparam logic [7:0] FUNC_GAINS  = 8'h10;
    localparam logic [7:0] FUNC_QUERY  = 8'h12;

    localparam int STORE_LEN  = 18;
    localparam int GAIN_CNT   = 9;
    localparam int ACK_LEN    = 8;
    localparam int ACK_IDX_W  = $clog2(ACK_LEN);
    localparam int STORE_IDX_W = $clog2(STORE_LEN);

    localparam logic [7:0] ACK_B0 = 8'hAA;
    localparam logic [7:0] ACK_B1 = 8'hAA;
    localparam logic [7:0] ACK_B2 = 8'hF0;
    localparam logic [7:0] ACK_B3 = 8'h03;
    localparam logic [7:0] ACK_B4 = 8'hBA;
    localparam logic [7:0] ACK_B5 = 8'h00;
    localparam logic [ACK_IDX_W-1:0] ACK_SUM_IDX  = ACK_IDX_W'(6);
    localparam logic [ACK_IDX_W-1:0] ACK_LAST_IDX = ACK_IDX_W'(ACK_LEN - 1);

    localparam logic [9:0] ACK_BASE_WIDE =
        10'(ACK_B0) + 10'(ACK_B1) + 10'(ACK_B2) + 10'(ACK_B3) + 10'(ACK_B4) + 10'(ACK_B5);
    localparam logic [7:0] ACK_BASE_SUM = ACK_BASE_WIDE[7:0];

    typedef struct packed {
        logic [7:0]                     frame_sum;
        logic [GAIN_CNT-1:0][15:0]      gains;
    } ack_cmd_t;

    typedef struct packed {
        logic     push;
        ack_cmd_t cmd;
    } push_req_t;

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_GOT_AA  = 6'b000010,
        PH_GOT_AF  = 6'b000100,
        PH_GOT_FN  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CKSUM   = 6'b100000
    } phase_t;

endpackage

FILE: hdl/scfp_front.sv
// Frame parser front end: header hunt, payload capture, checksum and gain update.
module scfp_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rx_valid,
    output logic                  rx_ready,
    input  logic [7:0]            rx_byte,
    input  logic                  q_full,
    output scfp_pkg::push_req_t   push_req
);

    scfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] func_reg, func_next;
    logic [7:0] remain_reg, remain_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [scfp_pkg::STORE_LEN];
    logic [scfp_pkg::GAIN_CNT-1:0][15:0] gain_reg, gain_next;
    logic [7:0] view [scfp_pkg::STORE_LEN];
    logic [scfp_pkg::GAIN_CNT-1:0][15:0] new_gains;
    logic accept;
    logic wr_en;
    logic [scfp_pkg::STORE_IDX_W-1:0] wr_idx;

    assign rx_ready = !q_full;
    assign accept   = rx_valid && rx_ready;
    assign wr_idx   = count_reg[scfp_pkg::STORE_IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < scfp_pkg::STORE_LEN; i++)
        begin
            view[i] = ((count_reg < 8'(scfp_pkg::STORE_LEN))
                       && (wr_idx == scfp_pkg::STORE_IDX_W'(i))) ? rx_byte : store_reg[i];
        end
        for (int g = 0; g < scfp_pkg::GAIN_CNT; g++)
        begin
            new_gains[g] = {view[2*g], view[2*g+1]};
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        func_next   = func_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        gain_next   = gain_reg;
        wr_en       = 1'b0;
        push_req.push           = 1'b0;
        push_req.cmd.frame_sum  = sum_reg;
        push_req.cmd.gains      = gain_reg;
        if (accept)
        begin
            unique case (phase_reg)
                scfp_pkg::PH_HUNT:
                begin
                    if (rx_byte == scfp_pkg::SYNC_0)
                    begin
                        phase_next = scfp_pkg::PH_GOT_AA;
                        sum_next   = rx_byte;
                    end
                end
                scfp_pkg::PH_GOT_AA:
                begin
                    if (rx_byte == scfp_pkg::SYNC_1)
                    begin
                        phase_next = scfp_pkg::PH_GOT_AF;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_HUNT;
                    end
                end
                scfp_pkg::PH_GOT_AF:
                begin
                    if (rx_byte != 8'd0 && rx_byte < scfp_pkg::FUNC_LIMIT)
                    begin
                        phase_next = scfp_pkg::PH_GOT_FN;
                        func_next  = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_HUNT;
                    end
                end
                scfp_pkg::PH_GOT_FN:
                begin
                    if (rx_byte <= scfp_pkg::MAX_LEN)
                    begin
                        phase_next  = scfp_pkg::PH_PAYLOAD;
                        remain_next = rx_byte;
                        count_next  = 8'd0;
                        sum_next    = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_HUNT;
                    end
                end
                scfp_pkg::PH_PAYLOAD:
                begin
                    if (remain_reg != 8'd0)
                    begin
                        wr_en       = (count_reg < 8'(scfp_pkg::STORE_LEN));
                        count_next  = count_reg + 8'd1;
                        remain_next = remain_reg - 8'd1;
                        sum_next    = sum_reg + rx_byte;
                        if (remain_reg == 8'd1)
                        begin
                            phase_next = scfp_pkg::PH_CKSUM;
                        end
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_HUNT;
                    end
                end
                scfp_pkg::PH_CKSUM:
                begin
                    phase_next = scfp_pkg::PH_HUNT;
                    wr_en      = (count_reg < 8'(scfp_pkg::STORE_LEN));
                    if (rx_byte == sum_reg)
                    begin
                        if (func_reg == scfp_pkg::FUNC_GAINS)
                        begin
                            gain_next          = new_gains;
                            push_req.cmd.gains = new_gains;
                        end
                        push_req.push = (func_reg == scfp_pkg::FUNC_GAINS)
                                     || (func_reg == scfp_pkg::FUNC_QUERY);
                    end
                end
                default:
                begin
                    phase_next = scfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= scfp_pkg::PH_HUNT;
            func_reg   <= 8'd0;
            remain_reg <= 8'd0;
            count_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            gain_reg   <= '0;
            for (int i = 0; i < scfp_pkg::STORE_LEN; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            func_reg   <= func_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            gain_reg   <= gain_next;
            if (wr_en)
            begin
                store_reg[wr_idx] <= rx_byte;
            end
        end
    end

endmodule

FILE: hdl/scfp_queue.sv
// Two-entry queue of acknowledge commands between the parser and the sender.
module scfp_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scfp_pkg::push_req_t   push_req,
    output logic                  full,
    input  logic                  pop,
    output logic                  q_valid,
    output scfp_pkg::ack_cmd_t    q_cmd
);

    scfp_pkg::ack_cmd_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_req.push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push_req.push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_req.push)
        begin
            mem[wr_ptr_reg] <= push_req.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push_req.push && full))
        else $error("Acknowledge command pushed into a full queue.");

endmodule

FILE: hdl/scfp_back.sv
// Acknowledge sender: plays out one eight-word acknowledge frame per queued command.
module scfp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  scfp_pkg::ack_cmd_t    q_cmd,
    output logic                  pop,
    output logic                  tx_valid,
    input  logic                  tx_ready,
    output logic [7:0]            tx_byte,
    output logic                  tx_last,
    output logic [scfp_pkg::GAIN_CNT-1:0][15:0] gains
);

    logic busy_reg, busy_next;
    logic [scfp_pkg::ACK_IDX_W-1:0] idx_reg, idx_next;
    scfp_pkg::ack_cmd_t cmd_reg;
    logic [7:0] ck_reg;
    logic done;

    assign tx_valid = busy_reg;
    assign tx_last  = busy_reg && (idx_reg == scfp_pkg::ACK_LAST_IDX);
    assign done     = tx_valid && tx_ready && tx_last;
    assign pop      = !busy_reg || done;
    assign gains    = cmd_reg.gains;

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    tx_byte = scfp_pkg::ACK_B0;
            3'd1:    tx_byte = scfp_pkg::ACK_B1;
            3'd2:    tx_byte = scfp_pkg::ACK_B2;
            3'd3:    tx_byte = scfp_pkg::ACK_B3;
            3'd4:    tx_byte = scfp_pkg::ACK_B4;
            3'd5:    tx_byte = scfp_pkg::ACK_B5;
            scfp_pkg::ACK_SUM_IDX: tx_byte = cmd_reg.frame_sum;
            default: tx_byte = ck_reg;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = q_valid;
            idx_next  = '0;
        end
        else if (tx_valid && tx_ready)
        begin
            idx_next = idx_reg + scfp_pkg::ACK_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_valid)
        begin
            cmd_reg <= q_cmd;
            ck_reg  <= q_cmd.frame_sum + scfp_pkg::ACK_BASE_SUM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && tx_ready && !tx_last)
        |=> (idx_reg == $past(idx_reg) + scfp_pkg::ACK_IDX_W'(1)) && tx_valid)
        else $error("Acknowledge word index did not advance after a transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && !tx_ready) |=> tx_valid && $stable(idx_reg))
        else $error("Acknowledge frame moved while the sink stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !q_valid) |=> !tx_valid)
        else $error("Sender stayed busy with no queued command.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && q_valid) |=> tx_valid && (idx_reg == '0))
        else $error("Next acknowledge frame did not start at its first word.");

endmodule

FILE: hdl/serial_command_frame_parser_top.sv
// Top level of the serial command frame parser.
//
//  channel | direction | handshake          | payload
//  rx      | in        | rx_valid/rx_ready  | rx_byte
//  tx      | out       | tx_valid/tx_ready  | tx_byte, tx_last, gain_a_p .. gain_c_d
//
// Each received word is taken on an rx_valid/rx_ready handshake; rx_ready drops only while the
// two-entry acknowledge queue is full. An acknowledge frame is eight words,
// one per cycle when the sink is ready, and the next frame follows at once.
// Reset returns the parser to header hunting and clears payload and gains in the parser.
// A stalled sink holds the current word and backs up into the queue, and then into rx_ready.
module serial_command_frame_parser_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    output logic               tx_valid,
    input  logic               tx_ready,
    output logic [7:0]         tx_byte,
    output logic               tx_last,
    output logic signed [15:0] gain_a_p,
    output logic signed [15:0] gain_a_i,
    output logic signed [15:0] gain_a_d,
    output logic signed [15:0] gain_b_p,
    output logic signed [15:0] gain_b_i,
    output logic signed [15:0] gain_b_d,
    output logic signed [15:0] gain_c_p,
    output logic signed [15:0] gain_c_i,
    output logic signed [15:0] gain_c_d
);

    scfp_pkg::push_req_t push_req;
    scfp_pkg::ack_cmd_t  q_cmd;
    logic                q_full;
    logic                q_valid;
    logic                pop;
    logic [scfp_pkg::GAIN_CNT-1:0][15:0] gains;

    scfp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push_req (push_req)
    );

    scfp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (push_req),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    scfp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .tx_valid (tx_valid),
        .tx_ready (tx_ready),
        .tx_byte  (tx_byte),
        .tx_last  (tx_last),
        .gains    (gains)
    );

    assign gain_a_p = $signed(gains[0]);
    assign gain_a_i = $signed(gains[1]);
    assign gain_a_d = $signed(gains[2]);
    assign gain_b_p = $signed(gains[3]);
    assign gain_b_i = $signed(gains[4]);
    assign gain_b_d = $signed(gains[5]);
    assign gain_c_p = $signed(gains[6]);
    assign gain_c_i = $signed(gains[7]);
    assign gain_c_d = $signed(gains[8]);

endmodule

FILE: test/serial_command_frame_parser_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame parser, checked word by word against a parser model.
module serial_command_frame_parser_top_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_ACK,
        ROW_QUIET
    } row_kind_t;

    typedef struct packed {
        logic [7:0] rx;
        row_kind_t  kind;
        logic [7:0] frame_total;
        logic [7:0] ck;
    } dir_row_t;

    typedef struct packed {
        logic [7:0]                         data;
        logic                               last;
        logic [scfp_pkg::GAIN_CNT-1:0][15:0] gains;
    } ack_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      rx_valid = 1'b0;
    logic                      rx_ready;
    logic [7:0]                rx_byte = 8'h00;
    logic                      tx_valid;
    logic                      tx_ready = 1'b0;
    logic [7:0]                tx_byte;
    logic                      tx_last;
    logic signed [15:0]        gain_a_p, gain_a_i, gain_a_d;
    logic signed [15:0]        gain_b_p, gain_b_i, gain_b_d;
    logic signed [15:0]        gain_c_p, gain_c_i, gain_c_d;
    logic [scfp_pkg::GAIN_CNT-1:0][15:0] dut_gains;

    row_kind_t  rx_kind = ROW_PREDICT;
    logic [7:0] rx_total = 8'h00;
    logic [7:0] rx_ck = 8'h00;

    scfp_pkg::phase_t          parse_state = scfp_pkg::PH_HUNT;
    logic [7:0]                frame_func = 8'h00;
    logic [5:0]                bytes_left = 6'd0;
    logic [5:0]                payload_seen = 6'd0;
    logic [7:0]                frame_sum = 8'h00;
    logic [7:0]                payload_mem [scfp_pkg::STORE_LEN] = '{default: 8'h00};
    logic [scfp_pkg::GAIN_CNT-1:0][15:0] gain_model = '0;

    ack_word_t ack_words_due [$];
    ack_word_t want;
    logic      ack_due;
    logic [7:0] ack_total;
    logic [7:0] ack_ck;

    int  bytes_sent = 0;
    int  frames_acked = 0;
    int  gain_loads = 0;
    int  words_checked = 0;
    int  mismatches = 0;
    int  calm_left = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    dir_row_t directed_rows [23] = '{
        '{8'hAA, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hAF, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h12, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h01, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h00, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h6C, ROW_ACK,     8'h6C, 8'h6D},
        '{8'hAA, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hAA, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hAF, ROW_QUIET,   8'h00, 8'h00},
        '{8'hAA, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hAF, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hF1, ROW_QUIET,   8'h00, 8'h00},
        '{8'hAA, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hAF, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h12, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h00, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hFF, ROW_QUIET,   8'h00, 8'h00},
        '{8'hAA, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hAF, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h10, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h01, ROW_PREDICT, 8'h00, 8'h00},
        '{8'h80, ROW_PREDICT, 8'h00, 8'h00},
        '{8'hEA, ROW_PREDICT, 8'h00, 8'h00}
    };

    assign dut_gains = {gain_c_d, gain_c_i, gain_c_p, gain_b_d, gain_b_i, gain_b_p,
                        gain_a_d, gain_a_i, gain_a_p};

    serial_command_frame_parser_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .tx_valid (tx_valid),
        .tx_ready (tx_ready),
        .tx_byte  (tx_byte),
        .tx_last  (tx_last),
        .gain_a_p (gain_a_p),
        .gain_a_i (gain_a_i),
        .gain_a_d (gain_a_d),
        .gain_b_p (gain_b_p),
        .gain_b_i (gain_b_i),
        .gain_b_d (gain_b_d),
        .gain_c_p (gain_c_p),
        .gain_c_i (gain_c_i),
        .gain_c_d (gain_c_d)
    );

    always #5 clk = ~clk;

    task automatic track_frame_byte(input logic [7:0] b, output logic ack,
                                    output logic [7:0] total);
        ack = 1'b0;
        total = 8'h00;
        if (parse_state == scfp_pkg::PH_HUNT && b == scfp_pkg::SYNC_0)
        begin
            parse_state = scfp_pkg::PH_GOT_AA;
            frame_sum = b;
        end
        else if (parse_state == scfp_pkg::PH_GOT_AA && b == scfp_pkg::SYNC_1)
        begin
            parse_state = scfp_pkg::PH_GOT_AF;
            frame_sum += b;
        end
        else if (parse_state == scfp_pkg::PH_GOT_AF && b != 8'h00
                 && b < scfp_pkg::FUNC_LIMIT)
        begin
            parse_state = scfp_pkg::PH_GOT_FN;
            frame_func = b;
            frame_sum += b;
        end
        else if (parse_state == scfp_pkg::PH_GOT_FN && b <= scfp_pkg::MAX_LEN)
        begin
            parse_state = scfp_pkg::PH_PAYLOAD;
            bytes_left = b[5:0];
            payload_seen = 6'd0;
            frame_sum += b;
        end
        else if (parse_state == scfp_pkg::PH_PAYLOAD && bytes_left != 6'd0)
        begin
            if (payload_seen < scfp_pkg::STORE_LEN)
                payload_mem[payload_seen] = b;
            payload_seen++;
            bytes_left--;
            frame_sum += b;
            if (bytes_left == 6'd0)
                parse_state = scfp_pkg::PH_CKSUM;
        end
        else if (parse_state == scfp_pkg::PH_CKSUM)
        begin
            parse_state = scfp_pkg::PH_HUNT;
            if (payload_seen < scfp_pkg::STORE_LEN)
                payload_mem[payload_seen] = b;
            if (b == frame_sum)
            begin
                if (frame_func == scfp_pkg::FUNC_GAINS)
                begin
                    for (int g = 0; g < scfp_pkg::GAIN_CNT; g++)
                        gain_model[g] = {payload_mem[2 * g], payload_mem[2 * g + 1]};
                    gain_loads++;
                end
                if (frame_func == scfp_pkg::FUNC_GAINS || frame_func == scfp_pkg::FUNC_QUERY)
                begin
                    ack = 1'b1;
                    total = frame_sum;
                end
            end
        end
        else
        begin
            parse_state = scfp_pkg::PH_HUNT;
        end
    endtask

    task automatic queue_ack(input logic [7:0] total, input logic [7:0] ck,
                             input logic [scfp_pkg::GAIN_CNT-1:0][15:0] gains);
        logic [7:0] frame [scfp_pkg::ACK_LEN];
        ack_word_t  w;
        frame = '{scfp_pkg::ACK_B0, scfp_pkg::ACK_B1, scfp_pkg::ACK_B2, scfp_pkg::ACK_B3,
                  scfp_pkg::ACK_B4, scfp_pkg::ACK_B5, total, ck};
        for (int k = 0; k < scfp_pkg::ACK_LEN; k++)
        begin
            w.data = frame[k];
            w.last = (k == scfp_pkg::ACK_LEN - 1);
            w.gains = gains;
            ack_words_due.push_back(w);
        end
        frames_acked++;
    endtask

    task automatic flag_word(input string why, input ack_word_t w);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %02h last %0b gains %h, got %02h last %0b gains %h",
                     why, w.data, w.last, w.gains, tx_byte, tx_last, dut_gains);
    endtask

    always @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            track_frame_byte(rx_byte, ack_due, ack_total);
            if (rx_kind == ROW_ACK)
            begin
                queue_ack(rx_total, rx_ck, '0);
            end
            else if (rx_kind == ROW_PREDICT && ack_due)
            begin
                ack_ck = scfp_pkg::ACK_B0 + scfp_pkg::ACK_B1 + scfp_pkg::ACK_B2
                       + scfp_pkg::ACK_B3 + scfp_pkg::ACK_B4 + scfp_pkg::ACK_B5 + ack_total;
                queue_ack(ack_total, ack_ck, gain_model);
            end
        end
        if (tx_valid && tx_ready)
        begin
            words_checked++;
            if (ack_words_due.size() == 0)
            begin
                flag_word("word with nothing pending", '0);
            end
            else
            begin
                want = ack_words_due.pop_front();
                if (want.data !== tx_byte || want.last !== tx_last || want.gains !== dut_gains)
                    flag_word("word mismatch", want);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input row_kind_t k,
                             input logic [7:0] total, input logic [7:0] ck);
        rx_valid <= 1'b1;
        rx_byte <= b;
        rx_kind <= k;
        rx_total <= total;
        rx_ck <= ck;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        bytes_sent++;
        if (idle_on)
        begin
            if (calm_left > 0)
            begin
                calm_left--;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                calm_left = $urandom_range(15, 40);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                rx_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] fr [$];
        logic [7:0] fcode;
        logic [7:0] len;
        logic [7:0] s;
        int         pick;
        int         flaw;
        int         r;
        int         n_pay;
        pick = $urandom_range(0, 99);
        flaw = (pick >= 8 && pick < 24) ? $urandom_range(1, 6) : 0;
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom));
        end
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                fcode = scfp_pkg::FUNC_GAINS;
            else if (r < 7)
                fcode = scfp_pkg::FUNC_QUERY;
            else if (r == 7)
                fcode = scfp_pkg::FUNC_LIMIT - 8'd1;
            else
                fcode = 8'($urandom_range(1, scfp_pkg::FUNC_LIMIT - 1));
            r = $urandom_range(0, 19);
            if (fcode == scfp_pkg::FUNC_GAINS && r < 6)
                len = 8'(scfp_pkg::STORE_LEN);
            else if (r < 12)
                len = 8'($urandom_range(1, 6));
            else if (r < 17)
                len = 8'($urandom_range(7, 20));
            else if (r < 19)
                len = 8'($urandom_range(21, scfp_pkg::MAX_LEN - 1));
            else
                len = scfp_pkg::MAX_LEN;
            if (flaw == 1)
                fcode = $urandom_range(0, 1) ? 8'h00
                                             : 8'($urandom_range(scfp_pkg::FUNC_LIMIT, 255));
            if (flaw == 2)
                len = 8'($urandom_range(scfp_pkg::MAX_LEN + 1, 255));
            if (flaw == 3)
                len = 8'h00;
            n_pay = (flaw == 2) ? 2 : int'(len);
            fr = {scfp_pkg::SYNC_0, scfp_pkg::SYNC_1, fcode, len};
            if (flaw == 4)
                fr.push_front(scfp_pkg::SYNC_0);
            for (int i = 0; i < n_pay; i++)
            begin
                r = $urandom_range(0, 7);
                case (r)
                    0: fr.push_back(8'h00);
                    1: fr.push_back(8'hFF);
                    2: fr.push_back(8'h80);
                    3: fr.push_back(8'h7F);
                    default: fr.push_back(8'($urandom));
                endcase
            end
            s = 8'h00;
            foreach (fr[i])
                s += fr[i];
            if (flaw == 5)
                s += 8'($urandom_range(1, 255));
            fr.push_back(s);
            if (flaw == 6)
                repeat ($urandom_range(1, fr.size() - 1)) void'(fr.pop_back());
        end
        foreach (fr[i])
            send_byte(fr[i], ROW_PREDICT, 8'h00, 8'h00);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                tx_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!idle_on || $urandom_range(0, 2) != 0)
            begin
                tx_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                tx_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_valid && rx_ready) || (tx_valid && tx_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [7:0] pb;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].kind,
                      directed_rows[i].frame_total, directed_rows[i].ck);

        while (bytes_sent < 150)
            send_random_frame();

        // The sink stalls while query frames keep coming, so the acknowledge queue fills.
        hold_req = 1'b1;
        repeat (6)
        begin
            pb = 8'($urandom);
            send_byte(scfp_pkg::SYNC_0, ROW_PREDICT, 8'h00, 8'h00);
            send_byte(scfp_pkg::SYNC_1, ROW_PREDICT, 8'h00, 8'h00);
            send_byte(scfp_pkg::FUNC_QUERY, ROW_PREDICT, 8'h00, 8'h00);
            send_byte(8'h01, ROW_PREDICT, 8'h00, 8'h00);
            send_byte(pb, ROW_PREDICT, 8'h00, 8'h00);
            send_byte(scfp_pkg::SYNC_0 + scfp_pkg::SYNC_1 + scfp_pkg::FUNC_QUERY + 8'h01 + pb,
                      ROW_PREDICT, 8'h00, 8'h00);
        end
        rx_valid <= 1'b0;
        while (ack_words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        while (bytes_sent < 290)
            send_random_frame();

        idle_on = 1'b0;
        while (bytes_sent < 340)
            send_random_frame();
        rx_valid <= 1'b0;

        while (ack_words_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes: directed frames, random and broken frames, a long sink stall",
                 bytes_sent);
        $display("and a finish without idling; %0d words from %0d acks (%0d gain loads), %0d bad.",
                 words_checked, frames_acked, gain_loads, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
